[rtl/ehm_pkg.sv]
package ehm_pkg;

    localparam int ENDPOINTS_DEF  = 16;
    localparam int WINDOW_MAX_DEF = 64;

    localparam int ENDPOINT_W = 4;
    localparam int CNT_W      = 7;
    localparam int RUN_W      = 16;
    localparam int RATE_W     = 17;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Depth of the command queue between front and back, and of the result queue.
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_UNKNOWN   = 2'd0,
        ST_HEALTHY   = 2'd1,
        ST_DEGRADED  = 2'd2,
        ST_UNHEALTHY = 2'd3
    } status_t;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_CHECK  = 1'b1
    } op_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PASSIVE_ENABLE   = 3'd0,
        REG_PASSIVE_STRATEGY = 3'd1,
        REG_HEALTHY_COUNT    = 3'd2,
        REG_UNHEALTHY_COUNT  = 3'd3,
        REG_WINDOW_LENGTH    = 3'd4,
        REG_MIN_SAMPLES      = 3'd5,
        REG_DEGRADED_RATE    = 3'd6,
        REG_UNHEALTHY_RATE   = 3'd7
    } reg_idx_t;

    // Configuration as seen by the back end; eff_len is already clamped.
    typedef struct packed {
        logic              passive_enable;
        logic              passive_strategy;
        logic [RUN_W-1:0]  healthy_count;
        logic [RUN_W-1:0]  unhealthy_count;
        logic [CNT_W-1:0]  eff_len;
        logic [CNT_W-1:0]  min_samples;
        logic [RATE_W-1:0] degraded_rate;
        logic [RATE_W-1:0] unhealthy_rate;
    } cfg_t;

    typedef struct packed {
        op_t                   op;
        logic [ENDPOINT_W-1:0] endpoint;
        logic                  success;
        logic                  out_of_range;
    } cmd_t;

    typedef struct packed {
        status_t          status;
        status_t          previous_status;
        logic             status_changed;
        logic             check_passed;
        logic [CNT_W-1:0] window_failures;
        logic [CNT_W-1:0] window_fill;
        logic [RUN_W-1:0] pass_streak;
        logic [RUN_W-1:0] fail_streak;
    } res_t;

endpackage

[rtl/ehm_fifo.sv]
module ehm_fifo
    import ehm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    data_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/ehm_front.sv]
module ehm_front
    import ehm_pkg::*;
#(
    parameter int ENDPOINTS = ENDPOINTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  operation,
    input  logic [ENDPOINT_W-1:0] endpoint,
    input  logic                  success,
    output logic                  full,
    output logic                  cmd_valid,
    output cmd_t                  cmd,
    input  logic                  cmd_pop
);

    cmd_t cmd_in;
    logic cmd_empty;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    // An endpoint beyond the table is tagged here so the back end never touches state.
    always_comb
    begin
        cmd_in.op           = op_t'(operation);
        cmd_in.endpoint     = endpoint;
        cmd_in.success      = success;
        cmd_in.out_of_range = (32'(endpoint) >= 32'(ENDPOINTS));
    end

    ehm_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_bits),
        .full    (full),
        .empty   (cmd_empty)
    );

    assign cmd       = cmd_t'(cmd_bits);
    assign cmd_valid = !cmd_empty;

endmodule

[rtl/ehm_back.sv]
module ehm_back
    import ehm_pkg::*;
#(
    parameter int ENDPOINTS  = ENDPOINTS_DEF,
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic clear_windows,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic res_pop,
    output logic res_empty,
    output res_t res
);

    localparam int TABLE_DEPTH = (ENDPOINTS < (2 ** ENDPOINT_W)) ? ENDPOINTS : (2 ** ENDPOINT_W);
    localparam int TIDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WIDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int PROD_W      = RATE_W + CNT_W;

    typedef enum logic [1:0] {
        BK_READ = 2'b01,
        BK_EXEC = 2'b10
    } bk_state_t;

    bk_state_t state_reg, state_next;

    // Endpoint table.
    logic [WINDOW_MAX-1:0] win_reg   [TABLE_DEPTH];
    logic [CNT_W-1:0]      fill_reg  [TABLE_DEPTH];
    logic [CNT_W-1:0]      tally_reg [TABLE_DEPTH];
    logic [RUN_W-1:0]      pass_reg  [TABLE_DEPTH];
    logic [RUN_W-1:0]      fail_reg  [TABLE_DEPTH];
    status_t               stat_reg  [TABLE_DEPTH];

    // Item held between the read and execute cycles.
    cmd_t                  a_cmd_reg;
    logic                  a_rec_reg;
    logic [WINDOW_MAX-1:0] a_win_reg,   a_win_next;
    logic [CNT_W-1:0]      a_fill_reg,  a_fill_next;
    logic [CNT_W-1:0]      a_tally_reg, a_tally_next;
    logic [RUN_W-1:0]      a_pass_reg;
    logic [RUN_W-1:0]      a_fail_reg;
    status_t               a_prev_reg;

    logic [TIDX_W-1:0]     rd_idx, wr_idx;
    logic [WINDOW_MAX-1:0] e_win, w_mask;
    logic [WINDOW_MAX:0]   shifted;
    logic                  fail_bit, drop_bit, rec_on;
    logic [CNT_W-1:0]      fill_up, tally_up;

    logic [PROD_W-1:0]     lhs, prod_unh, prod_deg;
    logic                  unh_hit, deg_hit, enough, passed;
    logic [RUN_W-1:0]      pass_n, fail_n;
    status_t               status_n;
    res_t                  res_in;
    logic                  res_full, res_push;
    logic [$bits(res_t)-1:0] res_bits;

    // ---------------- read cycle ----------------
    assign rd_idx   = cmd.endpoint[TIDX_W-1:0];
    assign e_win    = win_reg[rd_idx];
    assign fail_bit = ~cmd.success;
    assign rec_on   = (cmd.op == OP_RECORD) && cfg.passive_enable;
    assign shifted  = {e_win, fail_bit};
    // The oldest kept outcome falls out of the window; bits past the length are always zero.
    assign drop_bit = e_win[WIDX_W'(cfg.eff_len - 7'd1)];

    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            w_mask[i] = (32'(i) < 32'(cfg.eff_len));
        end
    end

    assign fill_up  = (fill_reg[rd_idx] >= cfg.eff_len) ? cfg.eff_len
                                                         : fill_reg[rd_idx] + 7'd1;
    assign tally_up = tally_reg[rd_idx] + CNT_W'(fail_bit) - CNT_W'(drop_bit);

    always_comb
    begin
        if (rec_on)
        begin
            a_win_next   = shifted[WINDOW_MAX-1:0] & w_mask;
            a_fill_next  = fill_up;
            a_tally_next = tally_up;
        end
        else
        begin
            a_win_next   = e_win;
            a_fill_next  = fill_reg[rd_idx];
            a_tally_next = tally_reg[rd_idx];
        end
    end

    assign cmd_pop = (state_reg == BK_READ) && cmd_valid && !res_full;

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            a_cmd_reg   <= cmd;
            a_rec_reg   <= rec_on;
            a_win_reg   <= a_win_next;
            a_fill_reg  <= a_fill_next;
            a_tally_reg <= a_tally_next;
            a_pass_reg  <= pass_reg[rd_idx];
            a_fail_reg  <= fail_reg[rd_idx];
            a_prev_reg  <= stat_reg[rd_idx];
        end
    end

    // ---------------- execute cycle ----------------
    // failures/fill >= T/65536 is tested as failures*65536 >= T*fill.
    assign lhs      = PROD_W'({a_tally_reg, 16'h0000});
    assign prod_unh = PROD_W'(cfg.unhealthy_rate) * PROD_W'(a_fill_reg);
    assign prod_deg = PROD_W'(cfg.degraded_rate) * PROD_W'(a_fill_reg);
    assign unh_hit  = (lhs >= prod_unh);
    assign deg_hit  = (lhs >= prod_deg);
    assign enough   = (a_fill_reg >= cfg.min_samples);

    always_comb
    begin
        status_n = a_prev_reg;
        pass_n   = a_pass_reg;
        fail_n   = a_fail_reg;
        passed   = 1'b0;
        if (a_cmd_reg.op == OP_RECORD)
        begin
            if (a_rec_reg && enough)
            begin
                if (unh_hit)
                begin
                    status_n = ST_UNHEALTHY;
                end
                else if (deg_hit)
                begin
                    status_n = ST_DEGRADED;
                end
                else
                begin
                    status_n = ST_HEALTHY;
                end
            end
        end
        else
        begin
            if (cfg.passive_strategy)
            begin
                passed = !enough || (a_fill_reg == '0) || !unh_hit;
            end
            else
            begin
                passed = a_cmd_reg.success;
            end
            if (passed)
            begin
                pass_n = (a_pass_reg == '1) ? a_pass_reg : a_pass_reg + 1'b1;
                fail_n = '0;
                if (pass_n >= cfg.healthy_count)
                begin
                    status_n = ST_HEALTHY;
                end
                else if (a_prev_reg == ST_UNHEALTHY)
                begin
                    status_n = ST_DEGRADED;
                end
            end
            else
            begin
                fail_n = (a_fail_reg == '1) ? a_fail_reg : a_fail_reg + 1'b1;
                pass_n = '0;
                if (fail_n >= cfg.unhealthy_count)
                begin
                    status_n = ST_UNHEALTHY;
                end
                else if (a_prev_reg == ST_HEALTHY)
                begin
                    status_n = ST_DEGRADED;
                end
            end
        end
    end

    always_comb
    begin
        if (a_cmd_reg.out_of_range)
        begin
            res_in = '0;
        end
        else
        begin
            res_in.status          = status_n;
            res_in.previous_status = a_prev_reg;
            res_in.status_changed  = (status_n != a_prev_reg);
            res_in.check_passed    = passed;
            res_in.window_failures = a_tally_reg;
            res_in.window_fill     = a_fill_reg;
            res_in.pass_streak     = pass_n;
            res_in.fail_streak     = fail_n;
        end
    end

    assign res_push = (state_reg == BK_EXEC);
    assign wr_idx   = a_cmd_reg.endpoint[TIDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                win_reg[i]   <= '0;
                fill_reg[i]  <= '0;
                tally_reg[i] <= '0;
                pass_reg[i]  <= '0;
                fail_reg[i]  <= '0;
                stat_reg[i]  <= ST_UNKNOWN;
            end
        end
        else if (clear_windows)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                win_reg[i]   <= '0;
                fill_reg[i]  <= '0;
                tally_reg[i] <= '0;
            end
        end
        else if (res_push && !a_cmd_reg.out_of_range)
        begin
            win_reg[wr_idx]   <= a_win_reg;
            fill_reg[wr_idx]  <= a_fill_reg;
            tally_reg[wr_idx] <= a_tally_reg;
            pass_reg[wr_idx]  <= pass_n;
            fail_reg[wr_idx]  <= fail_n;
            stat_reg[wr_idx]  <= status_n;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_READ:
            begin
                if (cmd_pop)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_READ;
            end
            default:
            begin
                state_next = BK_READ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_READ;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Space is checked before an item is read, so the push in the execute cycle always lands.
    ehm_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (res_pop),
        .rd_data (res_bits),
        .full    (res_full),
        .empty   (res_empty)
    );

    assign res = res_t'(res_bits);

endmodule

[rtl/endpoint_health_monitor_core.sv]
// Endpoint health monitor. Items enter through a queue-style push/full port and results
// leave through an empty/pop port, one result per item, in order. The back end handles
// each item in a read step, which reads the endpoint's table entry and shifts its outcome
// window, and an execute step for the two failure-rate multiplies, the status update and
// the write-back; it takes no new item until the last one is written back. The table is
// held in flip-flops and is cleared by reset at once, with no clearing pass. The user must
// write configuration registers through cfg_write, cfg_index and cfg_data only while the
// block is idle; the block itself does not enforce this. A write to window_length that
// changes the effective length empties every window at that edge.
module endpoint_health_monitor_core
    import ehm_pkg::*;
#(
    parameter int ENDPOINTS  = ENDPOINTS_DEF,
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  operation,
    input  logic [ENDPOINT_W-1:0] endpoint,
    input  logic                  success,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            status,
    output logic [1:0]            previous_status,
    output logic                  status_changed,
    output logic                  check_passed,
    output logic [CNT_W-1:0]      window_failures,
    output logic [CNT_W-1:0]      window_fill,
    output logic [RUN_W-1:0]      pass_streak,
    output logic [RUN_W-1:0]      fail_streak,
    input  logic                  cfg_write,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef struct packed {
        logic              passive_enable;
        logic              passive_strategy;
        logic [RUN_W-1:0]  healthy_count;
        logic [RUN_W-1:0]  unhealthy_count;
        logic [CNT_W-1:0]  window_length;
        logic [CNT_W-1:0]  min_samples;
        logic [RATE_W-1:0] degraded_rate;
        logic [RATE_W-1:0] unhealthy_rate;
    } regs_t;

    regs_t regs_reg, regs_next;
    cfg_t  cfg;
    logic  clear_windows;
    logic  cmd_valid, cmd_pop;
    cmd_t  cmd;
    res_t  res;

    function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] r;
        if (len == '0)
        begin
            r = CNT_W'(1);
        end
        else if (32'(len) > 32'(WINDOW_MAX))
        begin
            r = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            r = len;
        end
        return r;
    endfunction

    always_comb
    begin
        regs_next     = regs_reg;
        clear_windows = 1'b0;
        if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_PASSIVE_ENABLE:   regs_next.passive_enable   = cfg_data[0];
                REG_PASSIVE_STRATEGY: regs_next.passive_strategy = cfg_data[0];
                REG_HEALTHY_COUNT:    regs_next.healthy_count    = cfg_data[RUN_W-1:0];
                REG_UNHEALTHY_COUNT:  regs_next.unhealthy_count  = cfg_data[RUN_W-1:0];
                REG_WINDOW_LENGTH:
                begin
                    regs_next.window_length = cfg_data[CNT_W-1:0];
                    clear_windows = (eff_len(cfg_data[CNT_W-1:0])
                                     != eff_len(regs_reg.window_length));
                end
                REG_MIN_SAMPLES:      regs_next.min_samples      = cfg_data[CNT_W-1:0];
                REG_DEGRADED_RATE:    regs_next.degraded_rate    = cfg_data[RATE_W-1:0];
                REG_UNHEALTHY_RATE:   regs_next.unhealthy_rate   = cfg_data[RATE_W-1:0];
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.passive_enable   <= 1'b1;
            regs_reg.passive_strategy <= 1'b0;
            regs_reg.healthy_count    <= RUN_W'(2);
            regs_reg.unhealthy_count  <= RUN_W'(3);
            regs_reg.window_length    <= CNT_W'(64);
            regs_reg.min_samples      <= CNT_W'(10);
            regs_reg.degraded_rate    <= RATE_W'(6554);
            regs_reg.unhealthy_rate   <= RATE_W'(32768);
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    always_comb
    begin
        cfg.passive_enable   = regs_reg.passive_enable;
        cfg.passive_strategy = regs_reg.passive_strategy;
        cfg.healthy_count    = regs_reg.healthy_count;
        cfg.unhealthy_count  = regs_reg.unhealthy_count;
        cfg.eff_len          = eff_len(regs_reg.window_length);
        cfg.min_samples      = regs_reg.min_samples;
        cfg.degraded_rate    = regs_reg.degraded_rate;
        cfg.unhealthy_rate   = regs_reg.unhealthy_rate;
    end

    ehm_front #(
        .ENDPOINTS(ENDPOINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .operation (operation),
        .endpoint  (endpoint),
        .success   (success),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ehm_back #(
        .ENDPOINTS  (ENDPOINTS),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .clear_windows (clear_windows),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .res_pop       (pop),
        .res_empty     (empty),
        .res           (res)
    );

    assign status          = res.status;
    assign previous_status = res.previous_status;
    assign status_changed  = res.status_changed;
    assign check_passed    = res.check_passed;
    assign window_failures = res.window_failures;
    assign window_fill     = res.window_fill;
    assign pass_streak     = res.pass_streak;
    assign fail_streak     = res.fail_streak;

endmodule

[rtl/ehm_checker.sv]
module ehm_checker
    import ehm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic [1:0]       status,
    input logic [1:0]       previous_status,
    input logic             status_changed,
    input logic [CNT_W-1:0] window_failures,
    input logic [CNT_W-1:0] window_fill,
    input logic [RUN_W-1:0] pass_streak,
    input logic [RUN_W-1:0] fail_streak
);

    // The change flag must agree with the two status fields it summarizes.
    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status_changed == (status != previous_status)))
        else $error("status_changed disagrees with status fields");

    a_failures_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (window_failures <= window_fill))
        else $error("window holds more failures than outcomes");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(window_fill) <= 32'(WINDOW_MAX)))
        else $error("window fill beyond window size");

    // A pass clears the failing run and a failure clears the passing run.
    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pass_streak == '0 || fail_streak == '0))
        else $error("pass and fail streaks both nonzero");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(pass_streak)
                              && $stable(window_fill)))
        else $error("waiting result beat changed before it was taken");

endmodule

bind endpoint_health_monitor_core ehm_checker #(.WINDOW_MAX(WINDOW_MAX)) u_ehm_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb
    import ehm_pkg::*;
();

    typedef struct packed {
        op_t                   op;
        logic [ENDPOINT_W-1:0] ep;
        logic                  ok;
    } probe_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  operation = 1'b0;
    logic [ENDPOINT_W-1:0] endpoint = '0;
    logic                  success = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            status;
    logic [1:0]            previous_status;
    logic                  status_changed;
    logic                  check_passed;
    logic [CNT_W-1:0]      window_failures;
    logic [CNT_W-1:0]      window_fill;
    logic [RUN_W-1:0]      pass_streak;
    logic [RUN_W-1:0]      fail_streak;
    logic                  cfg_write = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    endpoint_health_monitor_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .endpoint        (endpoint),
        .success         (success),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .previous_status (previous_status),
        .status_changed  (status_changed),
        .check_passed    (check_passed),
        .window_failures (window_failures),
        .window_fill     (window_fill),
        .pass_streak     (pass_streak),
        .fail_streak     (fail_streak),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the per-endpoint table.
    logic [63:0]      win_bits  [16];
    logic [CNT_W-1:0] win_fill  [16];
    logic [CNT_W-1:0] win_fails [16];
    logic [RUN_W-1:0] pass_run  [16];
    logic [RUN_W-1:0] fail_run  [16];
    status_t          health    [16];

    // Shadow copy of the configuration registers, starting at their reset values.
    logic              sh_passive_en    = 1'b1;
    logic              sh_passive_strat = 1'b0;
    logic [RUN_W-1:0]  sh_healthy_need  = 16'd2;
    logic [RUN_W-1:0]  sh_unhealthy_need = 16'd3;
    logic [CNT_W-1:0]  sh_win_len       = 7'd64;
    logic [CNT_W-1:0]  sh_min_samp      = 7'd10;
    logic [RATE_W-1:0] sh_deg_rate      = 17'd6554;
    logic [RATE_W-1:0] sh_unh_rate      = 17'd32768;

    probe_t probe_q [$];
    res_t   due_results [$];
    probe_t tx_cur = '0;
    bit     tx_busy = 1'b0;
    int     tx_gap = 0;
    int     rx_hold = 0;
    bit     tx_idle_on = 1'b0;
    bit     rx_idle_on = 1'b0;
    bit     rx_freeze_req = 1'b0;
    bit     rx_freeze_done = 1'b0;
    int     err_cnt = 0;

    function automatic int window_span(logic [CNT_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > 64)
            return 64;
        return len;
    endfunction

    // failures / fill >= thr / 65536, compared without division.
    function automatic bit rate_reached(int failures, int fill, logic [RATE_W-1:0] thr);
        longint lhs;
        longint rhs;
        lhs = longint'(failures) << 16;
        rhs = longint'(thr) * fill;
        return lhs >= rhs;
    endfunction

    function automatic res_t health_step(probe_t p);
        res_t        r;
        status_t     prev;
        status_t     nxt;
        logic        passed;
        logic [63:0] bits;
        int          len;
        int          fill;
        int          idx;
        idx    = p.ep;
        prev   = health[idx];
        nxt    = prev;
        passed = 1'b0;
        if (p.op == OP_RECORD)
        begin
            if (sh_passive_en)
            begin
                len  = window_span(sh_win_len);
                bits = {win_bits[idx][62:0], ~p.ok};
                if (len < 64)
                    bits &= (64'd1 << len) - 64'd1;
                fill = win_fill[idx] + 1;
                if (fill > len)
                    fill = len;
                win_bits[idx]  = bits;
                win_fill[idx]  = CNT_W'(fill);
                win_fails[idx] = CNT_W'($countones(bits));
                if (fill >= sh_min_samp)
                begin
                    if (rate_reached(win_fails[idx], fill, sh_unh_rate))
                        nxt = ST_UNHEALTHY;
                    else if (rate_reached(win_fails[idx], fill, sh_deg_rate))
                        nxt = ST_DEGRADED;
                    else
                        nxt = ST_HEALTHY;
                end
            end
        end
        else
        begin
            if (sh_passive_strat)
            begin
                if (win_fill[idx] < sh_min_samp || win_fill[idx] == 0)
                    passed = 1'b1;
                else
                    passed = !rate_reached(win_fails[idx], win_fill[idx], sh_unh_rate);
            end
            else
                passed = p.ok;
            if (passed)
            begin
                if (pass_run[idx] != 16'hFFFF)
                    pass_run[idx]++;
                fail_run[idx] = '0;
                if (pass_run[idx] >= sh_healthy_need)
                    nxt = ST_HEALTHY;
                else if (prev == ST_UNHEALTHY)
                    nxt = ST_DEGRADED;
            end
            else
            begin
                if (fail_run[idx] != 16'hFFFF)
                    fail_run[idx]++;
                pass_run[idx] = '0;
                if (fail_run[idx] >= sh_unhealthy_need)
                    nxt = ST_UNHEALTHY;
                else if (prev == ST_HEALTHY)
                    nxt = ST_DEGRADED;
            end
        end
        health[idx] = nxt;
        r.status          = nxt;
        r.previous_status = prev;
        r.status_changed  = (nxt != prev);
        r.check_passed    = passed;
        r.window_failures = win_fails[idx];
        r.window_fill     = win_fill[idx];
        r.pass_streak     = pass_run[idx];
        r.fail_streak     = fail_run[idx];
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(12, 30);
    endfunction

    task automatic check_field(string fname, int want, int got);
        if (want != got)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                due_results.insert(due_results.size(), health_step(tx_cur));
                tx_busy = 1'b0;
                tx_gap  = tx_idle_on ? idle_len() : 0;
            end
            if (!tx_busy)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (probe_q.size() != 0)
                begin
                    tx_cur  = probe_q[0];
                    probe_q.delete(0);
                    tx_busy = 1'b1;
                end
            end
            push      <= tx_busy;
            operation <= tx_cur.op;
            endpoint  <= tx_cur.ep;
            success   <= tx_cur.ok;
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (due_results.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected beat, expected none, actual status %0d",
                             $time, status);
                end
                else
                begin
                    want = due_results[0];
                    due_results.delete(0);
                    check_field("status", want.status, status);
                    check_field("previous_status", want.previous_status, previous_status);
                    check_field("status_changed", want.status_changed, status_changed);
                    check_field("check_passed", want.check_passed, check_passed);
                    check_field("window_failures", want.window_failures, window_failures);
                    check_field("window_fill", want.window_fill, window_fill);
                    check_field("pass_streak", want.pass_streak, pass_streak);
                    check_field("fail_streak", want.fail_streak, fail_streak);
                end
                if (rx_idle_on)
                    rx_hold = idle_len();
            end
            // A long hold lets the block fill up and push back on the sender.
            if (rx_freeze_req && !rx_freeze_done)
            begin
                rx_hold        = 250;
                rx_freeze_done = 1'b1;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic enqueue_probe(op_t op, int ep, bit ok);
        probe_t p;
        p.op = op;
        p.ep = ENDPOINT_W'(ep);
        p.ok = ok;
        probe_q.insert(probe_q.size(), p);
    endtask

    // Waits until every queued beat has been sent and answered, then lets the pipe settle.
    task automatic drain();
        while (probe_q.size() != 0 || tx_busy || due_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int val);
        int e;
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        case (idx)
            REG_PASSIVE_ENABLE:   sh_passive_en = val[0];
            REG_PASSIVE_STRATEGY: sh_passive_strat = val[0];
            REG_HEALTHY_COUNT:    sh_healthy_need = val[15:0];
            REG_UNHEALTHY_COUNT:  sh_unhealthy_need = val[15:0];
            REG_WINDOW_LENGTH:
            begin
                if (window_span(val[6:0]) != window_span(sh_win_len))
                begin
                    for (e = 0; e < 16; e++)
                    begin
                        win_bits[e]  = '0;
                        win_fill[e]  = '0;
                        win_fails[e] = '0;
                    end
                end
                sh_win_len = val[6:0];
            end
            REG_MIN_SAMPLES:      sh_min_samp = val[6:0];
            REG_DEGRADED_RATE:    sh_deg_rate = val[16:0];
            REG_UNHEALTHY_RATE:   sh_unh_rate = val[16:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return 65535;
        return $urandom_range(1, 5);
    endfunction

    function automatic int pick_rate();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 65536;
        if (r == 2)
            return $urandom_range(65537, 131071);
        return $urandom_range(0, 65536);
    endfunction

    task automatic setup_random();
        int r;
        int len;
        write_reg(REG_PASSIVE_ENABLE, ($urandom_range(0, 4) != 0));
        write_reg(REG_PASSIVE_STRATEGY, $urandom_range(0, 1));
        write_reg(REG_HEALTHY_COUNT, pick_count());
        write_reg(REG_UNHEALTHY_COUNT, pick_count());
        r = $urandom_range(0, 9);
        if (r == 0)
            len = 0;
        else if (r == 1)
            len = $urandom_range(65, 127);
        else if (r == 2)
            len = 64;
        else if (r == 3)
            len = 1;
        else
            len = $urandom_range(2, 16);
        write_reg(REG_WINDOW_LENGTH, len);
        r = $urandom_range(0, 9);
        if (r == 0)
            write_reg(REG_MIN_SAMPLES, 0);
        else if (r == 1)
            write_reg(REG_MIN_SAMPLES, $urandom_range(64, 127));
        else
            write_reg(REG_MIN_SAMPLES, $urandom_range(1, window_span(len)));
        write_reg(REG_DEGRADED_RATE, pick_rate());
        write_reg(REG_UNHEALTHY_RATE, pick_rate());
    endtask

    // Traffic clusters on a few neighboring endpoints so their windows fill up,
    // and each endpoint gets its own failure ratio for the phase.
    task automatic random_burst(int count);
        int fail_pct [16];
        int hot;
        int e;
        int n;
        int ep;
        for (e = 0; e < 16; e++)
            fail_pct[e] = $urandom_range(0, 100);
        hot = $urandom_range(0, 15);
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 2) != 0)
                ep = (hot + $urandom_range(0, 2)) % 16;
            else
                ep = $urandom_range(0, 15);
            enqueue_probe(($urandom_range(0, 9) < 7) ? OP_RECORD : OP_CHECK, ep,
                          $urandom_range(0, 99) >= fail_pct[ep]);
        end
    endtask

    initial
    begin
        int i;
        int ph;
        for (i = 0; i < 16; i++)
        begin
            win_bits[i]  = '0;
            win_fill[i]  = '0;
            win_fails[i] = '0;
            pass_run[i]  = '0;
            fail_run[i]  = '0;
            health[i]    = ST_UNKNOWN;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Hysteresis on active checks, then a window that crosses the unhealthy
        // rate exactly once it holds enough samples.
        rx_idle_on = 1'b1;
        enqueue_probe(OP_CHECK, 0, 1'b1);
        enqueue_probe(OP_CHECK, 0, 1'b1);
        enqueue_probe(OP_CHECK, 0, 1'b0);
        repeat (3) enqueue_probe(OP_CHECK, 15, 1'b0);
        enqueue_probe(OP_CHECK, 15, 1'b1);
        for (i = 0; i < 10; i++)
            enqueue_probe(OP_RECORD, 2, i[0]);
        drain();

        // Recording off, passive checks on empty windows, zero hysteresis counts.
        write_reg(REG_PASSIVE_ENABLE, 0);
        write_reg(REG_PASSIVE_STRATEGY, 1);
        write_reg(REG_MIN_SAMPLES, 0);
        write_reg(REG_WINDOW_LENGTH, 0);
        write_reg(REG_HEALTHY_COUNT, 0);
        write_reg(REG_UNHEALTHY_COUNT, 0);
        write_reg(REG_DEGRADED_RATE, 65536);
        write_reg(REG_UNHEALTHY_RATE, 131071);
        enqueue_probe(OP_RECORD, 5, 1'b0);
        enqueue_probe(OP_CHECK, 5, 1'b0);
        enqueue_probe(OP_CHECK, 2, 1'b1);
        drain();

        // An oversized window length acts as the maximum; the unhealthy rate is
        // out of reach while an all-failure window still reaches degraded.
        write_reg(REG_PASSIVE_ENABLE, 1);
        write_reg(REG_WINDOW_LENGTH, 127);
        enqueue_probe(OP_RECORD, 6, 1'b0);
        enqueue_probe(OP_RECORD, 6, 1'b0);
        enqueue_probe(OP_CHECK, 6, 1'b1);
        drain();

        // Long streaks that stay short of the largest hysteresis counts.
        write_reg(REG_PASSIVE_STRATEGY, 0);
        write_reg(REG_HEALTHY_COUNT, 65535);
        write_reg(REG_UNHEALTHY_COUNT, 65535);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (i = 0; i < 20; i++)
        begin
            enqueue_probe(OP_CHECK, 3, 1'b1);
            enqueue_probe(OP_CHECK, 4, 1'b0);
        end
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            setup_random();
            tx_idle_on = (ph % 3 != 0);
            rx_idle_on = (ph % 4 != 1);
            if (ph == 2)
            begin
                tx_idle_on    = 1'b0;
                rx_freeze_req = 1'b1;
            end
            random_burst(155);
            drain();
        end

        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
rtl/ehm_pkg.sv
rtl/ehm_fifo.sv
rtl/ehm_front.sv
rtl/ehm_back.sv
rtl/endpoint_health_monitor_core.sv
rtl/ehm_checker.sv
tb/tb.sv
